// ----- hdl/wmvs_pkg.sv -----
// ============================================================================
// wmvs_pkg
// Shared constants, types and controller/datapath command structs for the
// moving-window mean / variance block.
// ============================================================================
package wmvs_pkg;

    localparam int WINDOW    = 16;
    localparam int SAMPLE_W  = 12;
    localparam int FILL_W    = $clog2(WINDOW + 1);
    localparam int ADDR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W     = $clog2(WINDOW * 4095 + 1);
    localparam int SQ_W      = 2 * SAMPLE_W;
    localparam int SQSUM_W   = $clog2(WINDOW * 4095 * 4095 + 1);
    localparam int DIV_W     = SQSUM_W;
    localparam int DCNT_W    = $clog2(DIV_W + 1);
    localparam int SPREAD_W  = 24;
    localparam int LIMIT_W   = 16;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

    // register index field of paddr (byte address / 4)
    localparam logic REG_LIMIT = 1'b0;

    // item kinds
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic item_take;   // apply accepted transaction to the window
        logic res_clr;     // zero mean and spread
        logic pass_start;  // rewind read index, zero accumulators
        logic rd;          // read entry at index, advance index
        logic sq_pass;     // pipeline works on squared deviations
        logic div_mean;    // start divider on the sample sum
        logic mean_take;   // capture quotient as mean
        logic spread_take; // capture square sum over WINDOW as spread
        logic result_load; // load output register
    } wmvs_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic rd_last;
        logic pipe_busy;
        logic div_busy;
    } wmvs_stat_t;

endpackage

// ----- hdl/wmvs_divider.sv -----
// ============================================================================
// wmvs_divider
// Restoring divider, one quotient bit per cycle. The dividend is loaded
// left-aligned so that the iteration count can be shorter than DIV_W.
// ============================================================================
module wmvs_divider
    import wmvs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DCNT_W-1:0] iters,
    input  logic [FILL_W-1:0] divisor,
    output logic              busy,
    output logic [DIV_W-1:0]  quotient
);

    logic              busy_reg, busy_next;
    logic [DCNT_W-1:0] count_reg, count_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [FILL_W-1:0] rem_reg, rem_next;
    logic [FILL_W:0]   rem_shift;
    logic              fits;

    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign fits      = (rem_shift >= {1'b0, divisor});

    always_comb
    begin
        busy_next  = busy_reg;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = iters;
            quo_next   = dividend;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            quo_next   = {quo_reg[DIV_W-2:0], fits};
            rem_next   = fits ? FILL_W'(rem_shift - {1'b0, divisor})
                              : rem_shift[FILL_W-1:0];
            count_next = count_reg - DCNT_W'(1);
            if (count_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ----- hdl/wmvs_datapath.sv -----
// ============================================================================
// wmvs_datapath
// Sample window, read pipeline with sum / squared-deviation accumulators,
// mean divider and the result register.
// ============================================================================
module wmvs_datapath
    import wmvs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  wmvs_cmd_t           cmd,
    output wmvs_stat_t          stat,
    input  logic                kind,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [LIMIT_W-1:0]  limit,
    output logic [FILL_W-1:0]   fill_count,
    output logic [SAMPLE_W-1:0] mean_value,
    output logic [SPREAD_W-1:0] spread,
    output logic                stable
);

    logic [SAMPLE_W-1:0] mem [WINDOW];

    logic [ADDR_W-1:0]   slot_reg;
    logic [FILL_W-1:0]   filled_reg;
    logic [FILL_W-1:0]   idx_reg;
    logic                rd_v_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                sq_v_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [SUM_W-1:0]    total_reg;
    logic [SQSUM_W-1:0]  sqsum_reg;
    logic [SAMPLE_W-1:0] mean_reg;
    logic [SPREAD_W-1:0] spread_reg;

    logic [FILL_W-1:0]   fill_out_reg;
    logic [SAMPLE_W-1:0] mean_out_reg;
    logic [SPREAD_W-1:0] spread_out_reg;
    logic                stable_out_reg;

    logic [SAMPLE_W-1:0] dev;
    logic                full;
    logic                div_start;
    logic [DIV_W-1:0]    div_dividend;
    logic [DCNT_W-1:0]   div_iters;
    logic                div_busy;
    logic [DIV_W-1:0]    div_quotient;

    assign full = (filled_reg == FILL_W'(WINDOW));
    assign dev  = (rd_data_reg >= mean_reg) ? (rd_data_reg - mean_reg)
                                            : (mean_reg - rd_data_reg);

    // window bookkeeping; only slots below the fill count are ever read,
    // so a clear needs no sweep of the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= '0;
            filled_reg <= '0;
        end
        else if (cmd.item_take)
        begin
            if (kind == KIND_CLEAR)
            begin
                slot_reg   <= '0;
                filled_reg <= '0;
            end
            else
            begin
                slot_reg <= (slot_reg == ADDR_W'(WINDOW - 1)) ? '0
                                                              : slot_reg + ADDR_W'(1);
                if (!full)
                begin
                    filled_reg <= filled_reg + FILL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_take && kind == KIND_ADD)
        begin
            mem[slot_reg] <= sample;
        end
        rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
    end

    // read pipeline: read -> (sum | square) -> square accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            rd_v_reg <= 1'b0;
            sq_v_reg <= 1'b0;
        end
        else
        begin
            if (cmd.pass_start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.rd)
            begin
                idx_reg <= idx_reg + FILL_W'(1);
            end
            rd_v_reg <= cmd.rd;
            sq_v_reg <= rd_v_reg && cmd.sq_pass;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= dev * dev;
        if (cmd.pass_start)
        begin
            total_reg <= '0;
            sqsum_reg <= '0;
        end
        else
        begin
            if (rd_v_reg && !cmd.sq_pass)
            begin
                total_reg <= total_reg + SUM_W'(rd_data_reg);
            end
            if (sq_v_reg)
            begin
                sqsum_reg <= sqsum_reg + SQSUM_W'(sq_reg);
            end
        end
        if (cmd.res_clr)
        begin
            mean_reg   <= '0;
            spread_reg <= '0;
        end
        else
        begin
            if (cmd.mean_take)
            begin
                mean_reg <= div_quotient[SAMPLE_W-1:0];
            end
            // variance is only formed on a full window: divide by WINDOW
            if (cmd.spread_take)
            begin
                spread_reg <= SPREAD_W'(sqsum_reg / SQSUM_W'(WINDOW));
            end
        end
        if (cmd.result_load)
        begin
            fill_out_reg   <= filled_reg;
            mean_out_reg   <= mean_reg;
            spread_out_reg <= spread_reg;
            stable_out_reg <= full && (spread_reg < SPREAD_W'(limit));
        end
    end

    assign div_start    = cmd.div_mean;
    assign div_dividend = {total_reg, {(DIV_W - SUM_W){1'b0}}};
    assign div_iters    = DCNT_W'(SUM_W);

    wmvs_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .iters    (div_iters),
        .divisor  (filled_reg),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    assign stat.empty     = (filled_reg == '0);
    assign stat.full      = full;
    assign stat.rd_last   = (idx_reg == filled_reg - FILL_W'(1));
    assign stat.pipe_busy = rd_v_reg || sq_v_reg;
    assign stat.div_busy  = div_busy;

    assign fill_count = fill_out_reg;
    assign mean_value = mean_out_reg;
    assign spread     = spread_out_reg;
    assign stable     = stable_out_reg;

endmodule

// ----- hdl/wmvs_ctrl.sv -----
// ============================================================================
// wmvs_ctrl
// Sequencer: sum pass, mean divide (both skipped when empty), squared-deviation
// pass and variance capture (full window only), hand-off to output register.
// ============================================================================
module wmvs_ctrl
    import wmvs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  wmvs_stat_t stat,
    output wmvs_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_SUM_RD,
        ST_SUM_DRAIN,
        ST_MEAN_DIV,
        ST_SQ_RD,
        ST_SQ_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item_take = 1'b1;
                    state_next    = ST_START;
                end
            end
            ST_START:
            begin
                cmd.res_clr    = 1'b1;
                cmd.pass_start = 1'b1;
                state_next     = stat.empty ? ST_FINISH : ST_SUM_RD;
            end
            ST_SUM_RD:
            begin
                cmd.rd = 1'b1;
                if (stat.rd_last)
                begin
                    state_next = ST_SUM_DRAIN;
                end
            end
            ST_SUM_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.div_mean = 1'b1;
                    state_next   = ST_MEAN_DIV;
                end
            end
            ST_MEAN_DIV:
            begin
                if (!stat.div_busy)
                begin
                    cmd.mean_take  = 1'b1;
                    cmd.pass_start = 1'b1;
                    state_next     = stat.full ? ST_SQ_RD : ST_FINISH;
                end
            end
            ST_SQ_RD:
            begin
                cmd.rd      = 1'b1;
                cmd.sq_pass = 1'b1;
                if (stat.rd_last)
                begin
                    state_next = ST_SQ_DRAIN;
                end
            end
            ST_SQ_DRAIN:
            begin
                cmd.sq_pass = 1'b1;
                if (!stat.pipe_busy)
                begin
                    cmd.spread_take = 1'b1;
                    state_next      = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.result_load = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/window_mean_variance_stability.sv -----
// ============================================================================
// window_mean_variance_stability
// Moving window of ADC samples: fill count, truncated mean, population
// variance and a stability flag against a programmable limit.
// ============================================================================
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------
//  in      | in_valid / in_stall        | kind, sample
//  out     | out_valid / out_stall      | fill_count, mean_value, spread, stable
//  apb     | psel, penable, pwrite, ... | stability_limit at byte address 0
//
//  One transaction at a time. A clear or an empty window goes straight to
//  hand-off. A partial window of F entries takes the sum pass and a 16-step
//  mean divide. A full window adds a second 16-entry memory read pass for the
//  squared deviations (the division by WINDOW is a shift).
//  A finished result sits in the output register; the next transaction is
//  taken meanwhile and only its final hand-off waits on out_stall.
//  Reset empties the window at once (fill count zero); limit resets to 100.
// ============================================================================
module window_mean_variance_stability
    import wmvs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [FILL_W-1:0]   fill_count,
    output logic [SAMPLE_W-1:0] mean_value,
    output logic [SPREAD_W-1:0] spread,
    output logic                stable,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    wmvs_cmd_t          cmd;
    wmvs_stat_t         stat;
    logic [LIMIT_W-1:0] limit_reg;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_LIMIT);
    assign prdata  = reg_sel ? PDATA_W'(limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    wmvs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    wmvs_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .kind       (kind),
        .sample     (sample),
        .limit      (limit_reg),
        .fill_count (fill_count),
        .mean_value (mean_value),
        .spread     (spread),
        .stable     (stable)
    );

`ifndef SYNTHESIS
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while previous transaction in flight");

    a_stable_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stable) |-> (fill_count == FILL_W'(WINDOW)))
        else $error("stable flag on a window that is not full");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fill_count == '0) |-> (mean_value == '0 && spread == '0))
        else $error("nonzero statistics on an empty window");

    a_partial_no_spread: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fill_count != FILL_W'(WINDOW)) |-> (spread == '0))
        else $error("spread reported before window full");
`endif

endmodule
